// ===== sv/rle_pkg.sv =====
package rle_pkg;

    localparam int ID_W   = 16;
    localparam int LEN_W  = 13;
    localparam int SLOT_W = 11;

    localparam logic signed [ID_W-1:0] NULL_ID = -16'sd2;

    localparam logic [2:0] FN_READ  = 3'd0;
    localparam logic [2:0] FN_WRITE = 3'd1;
    localparam logic [2:0] FN_COUNT = 3'd2;
    localparam logic [2:0] FN_CLEAR = 3'd3;
    localparam logic [2:0] FN_FILL  = 3'd4;

    typedef struct packed {
        logic signed [ID_W-1:0] id;
        logic [LEN_W-1:0]       len;
    } t_run;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_ROT,
        CMD_LOAD
    } t_cmd;

    // Rewrite plan broadcast to every cell: cells below start keep their run,
    // the next m cells take the new pieces, the rest take the run off places on.
    typedef struct packed {
        t_cmd              cmd;
        logic [SLOT_W-1:0] start;
        logic [1:0]        m;
        logic signed [2:0] off;
        t_run [2:0]        piece;
    } t_plan;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY
    } t_state;

endpackage

// ===== sv/rle_run_array_core.sv =====
// Run-length coded array of 16-bit block ids, held as (id, length) runs in a
// ring of cells.
// Input channel s_axis: one beat is one operation (read, write, count, clear,
// fill). tready is high only while the block is idle.
// Output channel m_axis: one beat per operation with the read id, the id
// count, the logical length and the store-full flag.
// Each operation rotates the whole ring once, so that every run passes the
// head cell where position, count and neighbours are picked up; then the
// cells are rewritten in place (split, merge, shift by up to two). The block
// takes no new beat until the rewrite is done and the result is loaded.
// The result sits in an output register: the next beat is accepted while it
// waits. If the receiver stalls, the block holds in its rewrite cycle until
// the output register is free.
// Reset (synchronous, active low) empties the array; cell contents are left
// as they are and the run count, state and output valid are cleared.
module rle_run_array_core #(
    parameter int MAX_LENGTH = 4096,
    parameter int RUN_SLOTS  = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // func[2:0], index[14:3], block_id[30:15], fill_length[43:31], zero pad
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_id[15:0], id_count[28:16], total_count[41:29], store_full[42], zero pad
    output logic [47:0] m_axis_tdata
);
    import rle_pkg::*;

    localparam int KW = (RUN_SLOTS > 1) ? $clog2(RUN_SLOTS) : 1;
    localparam int UW = $clog2(RUN_SLOTS + 1);

    t_state r_state, n_state;

    logic [2:0]             r_func;
    logic [11:0]            r_index;
    logic signed [ID_W-1:0] r_id;
    logic [LEN_W-1:0]       r_fill;

    logic [KW-1:0]          r_k;
    logic [UW-1:0]          r_used;
    logic [LEN_W-1:0]       r_pos;
    logic [LEN_W-1:0]       r_cnt;
    logic                   r_found;
    logic                   r_want;
    logic                   r_hasprev;
    logic                   r_hasnext;
    logic [KW-1:0]          r_j;
    logic [LEN_W-1:0]       r_jpos;
    t_run                   r_jrun;
    t_run                   r_last;
    t_run                   r_prev;
    t_run                   r_next;

    logic                   r_ovalid;
    logic [47:0]            r_odata;

    t_run                   head;
    t_plan                  plan;
    logic                   active;
    logic                   hit;
    logic [LEN_W:0]         reach;
    logic                   accept;
    logic                   load_out;

    // rewrite planning
    logic [LEN_W-1:0]       pre;
    logic [LEN_W-1:0]       post;
    logic [LEN_W-1:0]       gap;
    logic [LEN_W-1:0]       fill_sat;
    logic                   lm;
    logic                   rm;
    logic                   same;
    logic                   wr_ok;
    logic [1:0]             removed;
    logic [UW:0]            new_used;
    logic                   full;
    logic                   do_load;
    logic [UW-1:0]          n_used;
    logic [LEN_W-1:0]       n_total;
    logic signed [ID_W-1:0] res_id;
    logic [LEN_W-1:0]       res_cnt;

    rle_chain #(
        .RUN_SLOTS (RUN_SLOTS)
    ) u_chain (
        .i_clk  (i_clk),
        .i_plan (plan),
        .o_head (head)
    );

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign active        = {{(UW-KW){1'b0}}, r_k} < r_used;
    assign reach         = {1'b0, r_pos} + {1'b0, head.len};
    assign hit           = active && !r_found && ({2'b0, r_index} < reach);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    // control
    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        load_out      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_k == KW'(RUN_SLOTS - 1)) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if (!r_ovalid || m_axis_tready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // rewrite plan and result
    always_comb begin
        pre        = {1'b0, r_index} - r_jpos;
        post       = r_jrun.len - pre - 13'd1;
        gap        = {1'b0, r_index} - r_pos;
        fill_sat   = ({3'b0, r_fill} > 16'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : r_fill;
        wr_ok      = {4'b0, r_index} < 16'(MAX_LENGTH);
        same       = 1'b0;
        lm         = 1'b0;
        rm         = 1'b0;
        removed    = 2'd0;
        full       = 1'b0;
        do_load    = 1'b0;
        n_used     = r_used;
        n_total    = r_pos;
        plan.cmd   = CMD_HOLD;
        plan.start = '0;
        plan.m     = 2'd0;
        plan.off   = 3'sd0;
        plan.piece = '0;

        case (r_func)
            FN_WRITE: begin
                if (r_found) begin
                    same = (r_jrun.id == r_id);
                    lm   = r_hasprev && (pre == '0) && (r_prev.id == r_id);
                    rm   = r_hasnext && (post == '0) && (r_next.id == r_id);
                    if (pre != '0) begin
                        plan.piece[0] = '{id: r_jrun.id, len: pre};
                        plan.piece[1].id = r_id;
                        plan.piece[1].len = 13'd1 + (lm ? r_prev.len : '0)
                                          + (rm ? r_next.len : '0);
                        plan.piece[2] = '{id: r_jrun.id, len: post};
                        plan.m = (post != '0) ? 2'd3 : 2'd2;
                    end else begin
                        plan.piece[0].id = r_id;
                        plan.piece[0].len = 13'd1 + (lm ? r_prev.len : '0)
                                          + (rm ? r_next.len : '0);
                        plan.piece[1] = '{id: r_jrun.id, len: post};
                        plan.m = (post != '0) ? 2'd2 : 2'd1;
                    end
                    removed    = 2'd1 + {1'b0, lm} + {1'b0, rm};
                    plan.start = SLOT_W'(r_j) - SLOT_W'(lm);
                end else begin
                    // append past the end, padding the gap with a null run
                    if (gap != '0 && r_id != NULL_ID) begin
                        plan.piece[0] = '{id: NULL_ID, len: gap};
                        plan.piece[1] = '{id: r_id, len: 13'd1};
                        plan.m = 2'd2;
                    end else begin
                        plan.piece[0] = '{id: r_id, len: gap + 13'd1};
                        plan.m = 2'd1;
                    end
                    lm = (r_used != '0) && (r_last.id == plan.piece[0].id);
                    if (lm) begin
                        plan.piece[0].len = plan.piece[0].len + r_last.len;
                    end
                    removed    = {1'b0, lm};
                    plan.start = SLOT_W'(r_used) - SLOT_W'(lm);
                end
                plan.off = 3'(signed'({1'b0, removed})) - 3'(signed'({1'b0, plan.m}));
                new_used = {1'b0, r_used} + (UW+1)'(plan.m) - (UW+1)'(removed);
                // a write onto its own id leaves the list as it is
                if (wr_ok && !same) begin
                    if (new_used > (UW+1)'(RUN_SLOTS)) begin
                        full = 1'b1;
                    end else begin
                        do_load = 1'b1;
                        n_used  = UW'(new_used);
                        n_total = r_found ? r_pos : {1'b0, r_index} + 13'd1;
                    end
                end
            end
            FN_CLEAR: begin
                n_used  = '0;
                n_total = '0;
            end
            FN_FILL: begin
                if (fill_sat == '0) begin
                    n_used  = '0;
                    n_total = '0;
                end else begin
                    do_load       = 1'b1;
                    plan.m        = 2'd1;
                    plan.off      = 3'sd0;
                    plan.piece[0] = '{id: r_id, len: fill_sat};
                    n_used        = UW'(1);
                    n_total       = fill_sat;
                end
            end
            default: ;
        endcase
        new_used = {1'b0, r_used} + (UW+1)'(plan.m) - (UW+1)'(removed);

        if (r_state == S_SCAN) begin
            plan.cmd = CMD_ROT;
        end else if (load_out && do_load) begin
            plan.cmd = CMD_LOAD;
        end

        res_id  = (r_func == FN_READ) ? (r_found ? r_jrun.id : NULL_ID) : '0;
        res_cnt = (r_func == FN_COUNT) ? r_cnt : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_used   <= n_used;
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func    <= s_axis_tdata[2:0];
            r_index   <= s_axis_tdata[14:3];
            r_id      <= s_axis_tdata[30:15];
            r_fill    <= s_axis_tdata[43:31];
            r_k       <= '0;
            r_pos     <= '0;
            r_cnt     <= '0;
            r_found   <= 1'b0;
            r_want    <= 1'b0;
            r_hasnext <= 1'b0;
            r_hasprev <= 1'b0;
        end else if (r_state == S_SCAN) begin
            r_k <= r_k + KW'(1);
            if (active) begin
                r_pos  <= reach[LEN_W-1:0];
                r_last <= head;
                if (head.id == r_id) begin
                    r_cnt <= r_cnt + head.len;
                end
            end
            if (hit) begin
                r_found   <= 1'b1;
                r_j       <= r_k;
                r_jpos    <= r_pos;
                r_jrun    <= head;
                r_prev    <= r_last;
                r_hasprev <= (r_k != '0);
                r_want    <= 1'b1;
            end
            // the run after the hit passes the head in the next cycle
            if (r_want) begin
                r_want    <= 1'b0;
                r_hasnext <= active;
                r_next    <= head;
            end
        end
        if (load_out) begin
            r_odata <= {5'b0, full, n_total, res_cnt, res_id};
        end
    end

endmodule

// ===== sv/rle_cell.sv =====
module rle_cell #(
    parameter int SLOT = 0
) (
    input  logic                i_clk,
    input  rle_pkg::t_plan      i_plan,
    input  rle_pkg::t_run       i_rot,
    input  rle_pkg::t_run [4:0] i_nb,    // runs of cells SLOT-2 .. SLOT+2
    output rle_pkg::t_run       o_run
);
    import rle_pkg::*;

    localparam logic [SLOT_W-1:0] ME = SLOT_W'(SLOT);

    t_run              r_run;
    t_run              n_run;
    logic [SLOT_W-1:0] rel;
    logic [2:0]        sel;

    always_comb begin
        rel   = ME - i_plan.start;
        sel   = i_plan.off + 3'sd2;
        n_run = r_run;
        case (i_plan.cmd)
            CMD_ROT: begin
                n_run = i_rot;
            end
            CMD_LOAD: begin
                if (ME >= i_plan.start) begin
                    if (rel < SLOT_W'(i_plan.m)) begin
                        n_run = i_plan.piece[rel[1:0]];
                    end else begin
                        n_run = i_nb[sel];
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_run <= n_run;
    end

    assign o_run = r_run;

endmodule

// ===== sv/rle_chain.sv =====
module rle_chain #(
    parameter int RUN_SLOTS = 64
) (
    input  logic           i_clk,
    input  rle_pkg::t_plan i_plan,
    output rle_pkg::t_run  o_head
);
    import rle_pkg::*;

    t_run w_run [RUN_SLOTS];

    for (genvar g = 0; g < RUN_SLOTS; g++) begin : g_cell
        t_run [4:0] nb;
        for (genvar q = 0; q < 5; q++) begin : g_nb
            if (g + q - 2 >= 0 && g + q - 2 < RUN_SLOTS) begin : g_in
                assign nb[q] = w_run[g + q - 2];
            end else begin : g_edge
                assign nb[q] = w_run[g];
            end
        end

        rle_cell #(
            .SLOT (g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_plan (i_plan),
            .i_rot  (w_run[(g + 1) % RUN_SLOTS]),
            .i_nb   (nb),
            .o_run  (w_run[g])
        );
    end

    assign o_head = w_run[0];

endmodule
